// ===== hdl/cvr_pkg.sv =====
// cvr_pkg: shared types, constants and helper functions for the cold victim reservoir
// used by cvr_alu and cold_victim_reservoir; depends on nothing else
package cvr_pkg;

  localparam int NUM_BINS = 4;
  localparam int SLOTS_PER_BIN = 4;
  localparam int NSLOTS = NUM_BINS * SLOTS_PER_BIN;

  localparam int SLOT_W = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;
  localparam int BIN_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int SPB_W = (SLOTS_PER_BIN > 1) ? $clog2(SLOTS_PER_BIN) : 1;

  localparam int LFSR_W = 16;
  localparam int DIV_CW = $clog2(LFSR_W);
  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
  localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;
  localparam int SMALLEST_BIN_BYTES = 8;

  localparam int ID_W = 20;
  localparam int SIZE_W = 16;
  localparam int TOUCH_W = 63;
  localparam int AGE_W = 64;
  localparam int BC_W = 21;
  localparam int REM_W = BC_W;
  localparam int ALU_W = 64;

  localparam logic [1:0] ACT_SAMPLE = 2'd0;
  localparam logic [1:0] ACT_OFFER = 2'd1;
  localparam logic [1:0] ACT_VICTIM = 2'd2;

  localparam logic [BC_W-1:0] BLOCK_COUNT_RESET = 21'd4096;

  // one result transaction, lowest field last
  typedef struct packed {
    logic [ID_W-1:0] victim_id;
    logic            victim_found;
    logic            inserted;
    logic [ID_W-1:0] sample_index;
    logic            index_valid;
  } res_t;

  typedef struct packed {
    logic             lt;
    logic [ALU_W-1:0] diff;
  } alu_res_t;

  function automatic logic [BIN_W-1:0] size_bin(input logic [SIZE_W-1:0] bytes);
    logic [BIN_W-1:0] b;
    logic             found;
    b = BIN_W'(NUM_BINS - 1);
    found = 1'b0;
    for (int i = 0; i < NUM_BINS - 1; i++) begin
      if (!found && (32'(bytes) <= 32'(SMALLEST_BIN_BYTES << i))) begin
        b = BIN_W'(i);
        found = 1'b1;
      end
    end
    return b;
  endfunction

  function automatic logic [SLOT_W-1:0] bin_base(input logic [BIN_W-1:0] bin);
    return SLOT_W'(int'(bin) * SLOTS_PER_BIN);
  endfunction

  function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] s);
    return (s >> 1) ^ (s[0] ? LFSR_TAPS : '0);
  endfunction

endpackage

// ===== hdl/cvr_alu.sv =====
// cvr_alu: shared subtract and compare unit for the reservoir sequencer
// depends on cvr_pkg for the operand width and result type
module cvr_alu (
  input  logic [cvr_pkg::ALU_W-1:0] a,
  input  logic [cvr_pkg::ALU_W-1:0] b,
  output cvr_pkg::alu_res_t         res
);

  logic [cvr_pkg::ALU_W:0] full;

  // borrow out of a - b gives a < b
  assign full = {1'b0, a} - {1'b0, b};
  assign res.lt = full[cvr_pkg::ALU_W];
  assign res.diff = full[cvr_pkg::ALU_W-1:0];

endmodule

// ===== hdl/cold_victim_reservoir.sv =====
// cold_victim_reservoir: top level, sequencer around one shared compare/subtract unit
// depends on cvr_pkg and cvr_alu
//
// Usage:
//   s_* carries one request per transaction. s_tuser holds the action (0 sample,
//   1 offer, 2 victim request); s_tdata holds the candidate and request fields.
//   m_* returns exactly one result transaction for every request.
//   cfg_we/cfg_wdata write the block count; write it only while the block is idle.
// Sequencing:
//   a request is taken only when the sequencer is idle; it then runs alone.
//   sample: 16 restoring division steps on the unit, then the output state;
//   zero block count, invalid offer or unused action: straight to the output state.
//   offer: walks the slots of its bin, stops at the first free one, else ends in a final compare.
//   victim: walks the slots from the requested bin to the bin that yields
//   the victim, or to the last bin if none does.
//   every step goes through the single shared subtractor.
// Reset: synchronous rst empties every slot, seeds the LFSR with 0xACE1 and
//   sets the block count to 4096. No clearing pass is needed.
// Stall: a finished result sits in the output register; the next request is
//   taken meanwhile, and its result waits until m_tready frees the register.
module cold_victim_reservoir (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // cand_id[19:0], cand_valid[20], cand_size[36:21], cand_touch[99:37], req_size[115:100]
  input  logic [119:0] s_tdata,
  // action[1:0]
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // index_valid[0], sample_index[20:1], inserted[21], victim_found[22], victim_id[42:23]
  output logic [47:0]  m_tdata,
  input  logic         cfg_we,
  input  logic [20:0]  cfg_wdata
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV = 3'd1;
  localparam logic [2:0] ST_OFFER = 3'd2;
  localparam logic [2:0] ST_OFFER_CMP = 3'd3;
  localparam logic [2:0] ST_VICT = 3'd4;
  localparam logic [2:0] ST_OUT = 3'd5;

  logic [2:0] state;
  logic [cvr_pkg::BC_W-1:0] block_count;
  logic [cvr_pkg::LFSR_W-1:0] lfsr;

  logic [cvr_pkg::NSLOTS-1:0] slot_used;
  logic [cvr_pkg::ID_W-1:0] slot_entry [cvr_pkg::NSLOTS];
  logic [cvr_pkg::AGE_W-1:0] slot_age [cvr_pkg::NSLOTS];

  // working registers
  logic [cvr_pkg::LFSR_W-1:0] dvd;
  logic [cvr_pkg::REM_W-1:0] rem;
  logic [cvr_pkg::DIV_CW-1:0] cnt;
  logic [cvr_pkg::SLOT_W-1:0] k;
  logic [cvr_pkg::SPB_W-1:0] s;
  logic [cvr_pkg::BIN_W-1:0] bin;
  logic [cvr_pkg::SLOT_W-1:0] pick;
  logic have;
  logic [cvr_pkg::AGE_W-1:0] best;
  logic [cvr_pkg::ID_W-1:0] cid;
  logic [cvr_pkg::TOUCH_W-1:0] touch;
  cvr_pkg::res_t res;
  cvr_pkg::res_t out_res;
  logic out_valid;

  // request fields
  logic [cvr_pkg::ID_W-1:0] in_id;
  logic in_valid;
  logic [cvr_pkg::SIZE_W-1:0] in_size;
  logic [cvr_pkg::TOUCH_W-1:0] in_touch;
  logic [cvr_pkg::SIZE_W-1:0] in_req;
  logic [cvr_pkg::LFSR_W-1:0] lfsr_next;
  logic [cvr_pkg::BIN_W-1:0] in_bin;
  logic [cvr_pkg::BIN_W-1:0] req_bin;

  assign in_id = s_tdata[19:0];
  assign in_valid = s_tdata[20];
  assign in_size = s_tdata[36:21];
  assign in_touch = s_tdata[99:37];
  assign in_req = s_tdata[115:100];
  assign lfsr_next = cvr_pkg::lfsr_step(lfsr);
  assign in_bin = cvr_pkg::size_bin(in_size);
  assign req_bin = cvr_pkg::size_bin(in_req);

  // shared unit
  logic [cvr_pkg::ALU_W-1:0] alu_a;
  logic [cvr_pkg::ALU_W-1:0] alu_b;
  cvr_pkg::alu_res_t alu;
  logic [cvr_pkg::REM_W:0] rem_sh;

  assign rem_sh = {rem, dvd[cvr_pkg::LFSR_W-1]};

  always_comb begin
    alu_a = '0;
    alu_b = '0;
    case (state)
      ST_DIV: begin
        alu_a = cvr_pkg::ALU_W'(rem_sh);
        alu_b = cvr_pkg::ALU_W'(block_count);
      end
      ST_OFFER: begin
        alu_a = best;
        alu_b = slot_age[k];
      end
      ST_OFFER_CMP: begin
        alu_a = cvr_pkg::ALU_W'(touch);
        alu_b = best;
      end
      ST_VICT: begin
        alu_a = slot_age[k];
        alu_b = best;
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  cvr_alu u_alu (
    .a  (alu_a),
    .b  (alu_b),
    .res(alu)
  );

  logic [cvr_pkg::REM_W-1:0] rem_next;
  logic take;
  logic have_next;
  logic [cvr_pkg::SLOT_W-1:0] pick_next;
  logic last_slot;
  logic last_bin;

  assign rem_next = alu.lt ? rem_sh[cvr_pkg::REM_W-1:0] : alu.diff[cvr_pkg::REM_W-1:0];
  // victim walk: keep the first coldest used slot of the current bin
  assign take = slot_used[k] && (!have || alu.lt);
  assign have_next = have || take;
  assign pick_next = take ? k : pick;
  assign last_slot = (s == cvr_pkg::SPB_W'(cvr_pkg::SLOTS_PER_BIN - 1));
  assign last_bin = (bin == cvr_pkg::BIN_W'(cvr_pkg::NUM_BINS - 1));

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata = {5'b0, out_res};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      block_count <= cvr_pkg::BLOCK_COUNT_RESET;
      lfsr <= cvr_pkg::LFSR_SEED;
      slot_used <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        block_count <= cfg_wdata;
      end
      // output register loads in ST_OUT, otherwise drains on m_tready
      if (state == ST_OUT) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            res <= '0;
            case (s_tuser)
              cvr_pkg::ACT_SAMPLE: begin
                if (block_count != '0) begin
                  lfsr <= lfsr_next;
                  dvd <= lfsr_next;
                  rem <= '0;
                  cnt <= '0;
                  state <= ST_DIV;
                end else begin
                  state <= ST_OUT;
                end
              end
              cvr_pkg::ACT_OFFER: begin
                if (in_valid) begin
                  cid <= in_id;
                  touch <= in_touch;
                  k <= cvr_pkg::bin_base(in_bin);
                  s <= '0;
                  best <= '0;
                  pick <= cvr_pkg::bin_base(in_bin);
                  state <= ST_OFFER;
                end else begin
                  state <= ST_OUT;
                end
              end
              cvr_pkg::ACT_VICTIM: begin
                bin <= req_bin;
                k <= cvr_pkg::bin_base(req_bin);
                s <= '0;
                have <= 1'b0;
                best <= '0;
                pick <= cvr_pkg::bin_base(req_bin);
                state <= ST_VICT;
              end
              default: begin
                state <= ST_OUT;
              end
            endcase
          end
        end
        ST_DIV: begin
          rem <= rem_next;
          dvd <= dvd << 1;
          cnt <= cnt + 1'b1;
          if (cnt == cvr_pkg::DIV_CW'(cvr_pkg::LFSR_W - 1)) begin
            res.index_valid <= 1'b1;
            res.sample_index <= rem_next[cvr_pkg::ID_W-1:0];
            state <= ST_OUT;
          end
        end
        ST_OFFER: begin
          if (!slot_used[k]) begin
            // first free slot wins at once
            slot_used[k] <= 1'b1;
            slot_entry[k] <= cid;
            slot_age[k] <= cvr_pkg::AGE_W'(touch);
            res.inserted <= 1'b1;
            state <= ST_OUT;
          end else begin
            if (alu.lt) begin
              best <= slot_age[k];
              pick <= k;
            end
            if (last_slot) begin
              state <= ST_OFFER_CMP;
            end else begin
              s <= s + 1'b1;
              k <= k + 1'b1;
            end
          end
        end
        ST_OFFER_CMP: begin
          // replace the warmest slot only if the candidate is strictly colder
          if (alu.lt) begin
            slot_used[pick] <= 1'b1;
            slot_entry[pick] <= cid;
            slot_age[pick] <= cvr_pkg::AGE_W'(touch);
            res.inserted <= 1'b1;
          end
          state <= ST_OUT;
        end
        ST_VICT: begin
          if (take) begin
            best <= slot_age[k];
          end
          // have_next is low whenever the walk moves on to the next bin
          have <= have_next;
          pick <= pick_next;
          if (last_slot) begin
            if (have_next) begin
              slot_used[pick_next] <= 1'b0;
              res.victim_found <= 1'b1;
              res.victim_id <= slot_entry[pick_next];
              state <= ST_OUT;
            end else if (last_bin) begin
              state <= ST_OUT;
            end else begin
              bin <= bin + 1'b1;
              k <= k + 1'b1;
              s <= '0;
            end
          end else begin
            s <= s + 1'b1;
            k <= k + 1'b1;
          end
        end
        ST_OUT: begin
          if (!out_valid || m_tready) begin
            out_res <= res;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // one request in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request taken while another is in flight");

  // a result reports at most one kind of outcome
  a_one_outcome: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($countones({m_tdata[0], m_tdata[21], m_tdata[22]}) <= 1))
    else $error("result carries more than one outcome");

  // the lfsr never falls into the all-zero lockup state
  a_lfsr_live: assert property (@(posedge clk) disable iff (rst)
    lfsr != '0)
    else $error("lfsr reached zero");

  // a division that has run always yields a valid sample index
  a_sample_after_div: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && $past(state) == ST_DIV) |-> res.index_valid)
    else $error("division finished without an index");

endmodule
